@@ design/hkr_pkg.sv @@
// Shared types, constants and lookup tables for the HID keyboard report decoder.
// No dependencies; every other design file refers to this package by scoped names.
`default_nettype none
package hkr_pkg;

    // number of keycode slots in one boot report
    localparam int KEY_SLOTS = 6;
    // candidate events per report: presses over current slots, then releases over previous
    localparam int EV_SLOTS = 2 * KEY_SLOTS;

    localparam int ASCII_ROM_SIZE = 192;

    localparam logic [7:0] SHIFT_OFFSET = 8'h80;
    localparam logic [7:0] MOD_SHIFT    = 8'h22;
    localparam logic [7:0] MOD_CTRL     = 8'h11;
    localparam logic [7:0] MOD_ALT      = 8'h04;
    localparam logic [7:0] MOD_ALTGR    = 8'h40;

    // input word: one boot keyboard report
    typedef struct packed {
        logic [7:0] modifier_bits;
        logic [7:0] key_slot_0;
        logic [7:0] key_slot_1;
        logic [7:0] key_slot_2;
        logic [7:0] key_slot_3;
        logic [7:0] key_slot_4;
        logic [7:0] key_slot_5;
    } report_t;

    // output word: one key event
    typedef struct packed {
        logic [7:0] event_code;
        logic       is_special;
        logic       is_release;
        logic       ctrl_held;
        logic       shift_held;
        logic       alt_held;
        logic       altgr_held;
        logic       last_event;
    } key_event_t;

    // classified report handed from front to back
    typedef struct packed {
        logic [7:0]                   mods;
        logic [EV_SLOTS-1:0][7:0]     keys;   // [KEY_SLOTS-1:0] current, upper half previous
        logic [EV_SLOTS-1:0]          mask;   // events still to emit
    } job_t;

    // keycode to ASCII; entries from SHIFT_OFFSET up are the shifted map
    localparam logic [7:0] ASCII_ROM [ASCII_ROM_SIZE] = '{
        8'h00,8'h00,8'h00,8'h00,8'h61,8'h62,8'h63,8'h64,
        8'h65,8'h66,8'h67,8'h68,8'h69,8'h6A,8'h6B,8'h6C,
        8'h6D,8'h6E,8'h6F,8'h70,8'h71,8'h72,8'h73,8'h74,
        8'h75,8'h76,8'h77,8'h78,8'h79,8'h7A,8'h31,8'h32,
        8'h33,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,8'h30,
        8'h0D,8'h1B,8'h08,8'h09,8'h20,8'h2D,8'h3D,8'h5B,
        8'h5D,8'h00,8'h5C,8'h3B,8'h27,8'h60,8'h2C,8'h2E,
        8'h2F,8'h00,8'h81,8'h82,8'h83,8'h84,8'h85,8'h86,
        8'h87,8'h88,8'h89,8'h8A,8'h8B,8'h8C,8'h00,8'h00,
        8'h00,8'h1A,8'h0F,8'h0B,8'h7F,8'h0E,8'h0C,8'h14,
        8'h13,8'h12,8'h11,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h41,8'h42,8'h43,8'h44,
        8'h45,8'h46,8'h47,8'h48,8'h49,8'h4A,8'h4B,8'h4C,
        8'h4D,8'h4E,8'h4F,8'h50,8'h51,8'h52,8'h53,8'h54,
        8'h55,8'h56,8'h57,8'h58,8'h59,8'h5A,8'h21,8'h40,
        8'h23,8'h24,8'h25,8'h5E,8'h26,8'h2A,8'h28,8'h29,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h5F,8'h2B,8'h7B,
        8'h7D,8'h7C,8'h00,8'h3A,8'h22,8'h7E,8'h3C,8'h3E,
        8'h3F,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00
    };

    // keycode to first scan-table index holding it; 0 when absent
    function automatic logic [7:0] scan_index(input logic [7:0] keycode);
        case (keycode) inside
            [8'd4:8'd29]:    scan_index = keycode + 8'd61;
            [8'd58:8'd69]:   scan_index = keycode + 8'd54;
            [8'd104:8'd114]: scan_index = keycode + 8'd20;
            8'd226: scan_index = 8'd1;    8'd225: scan_index = 8'd2;
            8'd224: scan_index = 8'd3;    8'd229: scan_index = 8'd4;
            8'd230: scan_index = 8'd5;    8'd228: scan_index = 8'd6;
            8'd227: scan_index = 8'd7;    8'd231: scan_index = 8'd8;
            8'd83:  scan_index = 8'd9;    8'd71:  scan_index = 8'd10;
            8'd57:  scan_index = 8'd11;   8'd70:  scan_index = 8'd12;
            8'd148: scan_index = 8'd13;   8'd73:  scan_index = 8'd14;
            8'd74:  scan_index = 8'd15;   8'd72:  scan_index = 8'd16;
            8'd135: scan_index = 8'd17;   8'd101: scan_index = 8'd18;
            8'd138: scan_index = 8'd19;   8'd139: scan_index = 8'd20;
            8'd75:  scan_index = 8'd21;   8'd78:  scan_index = 8'd22;
            8'd77:  scan_index = 8'd23;   8'd80:  scan_index = 8'd24;
            8'd82:  scan_index = 8'd25;   8'd79:  scan_index = 8'd26;
            8'd81:  scan_index = 8'd27;   8'd41:  scan_index = 8'd30;
            8'd43:  scan_index = 8'd31;   8'd40:  scan_index = 8'd32;
            8'd42:  scan_index = 8'd33;   8'd76:  scan_index = 8'd34;
            8'd44:  scan_index = 8'd35;   8'd52:  scan_index = 8'd36;
            8'd51:  scan_index = 8'd37;   8'd54:  scan_index = 8'd38;
            8'd45:  scan_index = 8'd39;   8'd55:  scan_index = 8'd40;
            8'd56:  scan_index = 8'd41;   8'd47:  scan_index = 8'd42;
            8'd48:  scan_index = 8'd43;   8'd46:  scan_index = 8'd44;
            8'd49:  scan_index = 8'd45;   8'd39:  scan_index = 8'd48;
            8'd30:  scan_index = 8'd49;   8'd31:  scan_index = 8'd50;
            8'd32:  scan_index = 8'd51;   8'd33:  scan_index = 8'd52;
            8'd34:  scan_index = 8'd53;   8'd35:  scan_index = 8'd54;
            8'd36:  scan_index = 8'd55;   8'd37:  scan_index = 8'd56;
            8'd38:  scan_index = 8'd57;   8'd103: scan_index = 8'd94;
            8'd88:  scan_index = 8'd95;   8'd98:  scan_index = 8'd96;
            8'd89:  scan_index = 8'd97;   8'd90:  scan_index = 8'd98;
            8'd91:  scan_index = 8'd99;   8'd92:  scan_index = 8'd100;
            8'd93:  scan_index = 8'd101;  8'd94:  scan_index = 8'd102;
            8'd95:  scan_index = 8'd103;  8'd96:  scan_index = 8'd104;
            8'd97:  scan_index = 8'd105;  8'd85:  scan_index = 8'd106;
            8'd87:  scan_index = 8'd107;  8'd133: scan_index = 8'd108;
            8'd86:  scan_index = 8'd109;  8'd99:  scan_index = 8'd110;
            8'd84:  scan_index = 8'd111;  8'd182: scan_index = 8'd135;
            8'd129: scan_index = 8'd138;  8'd127: scan_index = 8'd139;
            8'd120: scan_index = 8'd140;  8'd128: scan_index = 8'd143;
            8'd205: scan_index = 8'd144;  8'd102: scan_index = 8'd145;
            8'd130: scan_index = 8'd148;  8'd181: scan_index = 8'd151;
            8'd183: scan_index = 8'd152;  8'd131: scan_index = 8'd153;
            default: scan_index = 8'd0;
        endcase
    endfunction

endpackage
`default_nettype wire

@@ design/hkr_front.sv @@
// Front end: accepts reports, finds new and dropped keys, keeps previous keys.
// Depends on hkr_pkg.
`default_nettype none
module hkr_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire hkr_pkg::report_t s_data,
    input  wire logic             q_full,
    output logic                  q_push,
    output hkr_pkg::job_t         q_job
);

    localparam int NK = hkr_pkg::KEY_SLOTS;

    logic [NK-1:0][7:0] prev_keys_reg, prev_keys_next;
    logic [NK-1:0][7:0] cur;
    logic [NK-1:0]      press, release_m;
    logic               accept;

    assign cur = {s_data.key_slot_5, s_data.key_slot_4, s_data.key_slot_3,
                  s_data.key_slot_2, s_data.key_slot_1, s_data.key_slot_0};

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // classify: new keys in slot order, then keys gone since last report
    always_comb begin
        logic dup_c, in_p, dup_p, in_c;
        for (int i = 0; i < NK; i++) begin
            dup_c = 1'b0;
            dup_p = 1'b0;
            in_p  = 1'b0;
            in_c  = 1'b0;
            for (int j = 0; j < NK; j++) begin
                if (j < i && cur[j] == cur[i]) dup_c = 1'b1;
                if (j < i && prev_keys_reg[j] == prev_keys_reg[i]) dup_p = 1'b1;
                if (prev_keys_reg[j] == cur[i]) in_p = 1'b1;
                if (cur[j] == prev_keys_reg[i]) in_c = 1'b1;
            end
            press[i]     = (cur[i] != 8'd0) && !dup_c && !in_p;
            release_m[i] = (prev_keys_reg[i] != 8'd0) && !dup_p && !in_c;
        end
    end

    // job word; reports with no change are dropped here
    always_comb begin
        q_job.mods = s_data.modifier_bits;
        q_job.keys = {prev_keys_reg, cur};
        q_job.mask = {release_m, press};
        q_push     = accept && ((press | release_m) != '0);
    end

    // previous keys follow every accepted report
    always_comb begin
        prev_keys_next = prev_keys_reg;
        if (accept) begin
            prev_keys_next = cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_keys_reg <= '0;
        end else begin
            prev_keys_reg <= prev_keys_next;
        end
    end

endmodule
`default_nettype wire

@@ design/hkr_queue.sv @@
// Job queue between front and back ends, small register file with pointers.
// Depends on hkr_pkg.
`default_nettype none
module hkr_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire hkr_pkg::job_t push_job,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output hkr_pkg::job_t      head_job
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    hkr_pkg::job_t mem [DEPTH];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_job   = mem[rd_ptr_reg];

    // pointer and fill tracking
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage write
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

@@ design/hkr_back.sv @@
// Back end: walks job events, one per cycle unless stalled, to an output register.
// Depends on hkr_pkg (tables, scan_index).
`default_nettype none
module hkr_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          head_valid,
    input  wire hkr_pkg::job_t head_job,
    output logic               pop,
    output logic               m_valid,
    input  wire logic          m_ready,
    output hkr_pkg::key_event_t m_data
);

    localparam int NE = hkr_pkg::EV_SLOTS;
    localparam int NK = hkr_pkg::KEY_SLOTS;

    logic [NE-1:0]       done_reg, done_next;
    logic [NE-1:0]       remaining, sel;
    logic                m_valid_reg, m_valid_next;
    hkr_pkg::key_event_t m_data_reg, m_data_next;
    logic [7:0]          key, idx, ascii;
    logic                is_rel, shift, last, load, emit;

    assign remaining = head_job.mask & ~done_reg;
    assign sel       = remaining & (~remaining + 1'b1);
    assign last      = ((remaining & ~sel) == '0);

    assign load = !m_valid_reg || m_ready;
    assign emit = load && head_valid;
    assign pop  = emit && last;

    // pick the key of the lowest pending event
    always_comb begin
        key    = 8'd0;
        is_rel = 1'b0;
        for (int i = 0; i < NE; i++) begin
            if (sel[i]) begin
                key    = head_job.keys[i];
                is_rel = (i >= NK);
            end
        end
    end

    // code lookup: ASCII map first, scan index as fallback
    always_comb begin
        shift = ((head_job.mods & hkr_pkg::MOD_SHIFT) != 8'd0);
        idx   = key + (shift ? hkr_pkg::SHIFT_OFFSET : 8'd0);
        ascii = (idx[7:6] == 2'b11) ? 8'd0 : hkr_pkg::ASCII_ROM[idx];
        m_data_next.event_code = (ascii == 8'd0) ? hkr_pkg::scan_index(key) : ascii;
        m_data_next.is_special = (ascii == 8'd0);
        m_data_next.is_release = is_rel;
        m_data_next.ctrl_held  = ((head_job.mods & hkr_pkg::MOD_CTRL) != 8'd0);
        m_data_next.shift_held = shift;
        m_data_next.alt_held   = ((head_job.mods & hkr_pkg::MOD_ALT) != 8'd0);
        m_data_next.altgr_held = ((head_job.mods & hkr_pkg::MOD_ALTGR) != 8'd0);
        m_data_next.last_event = last;
    end

    // progress through the current job
    always_comb begin
        done_next    = done_reg;
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = head_valid;
        end
        if (emit) begin
            done_next = last ? '0 : (done_reg | sel);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            done_reg    <= done_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

@@ design/hid_keyboard_report_to_key_events.sv @@
// HID boot keyboard report to key events: top level (front end, job queue, back end).
// The first event of a report goes through the job queue, then the back end's output register.
// Events leave the back end's output register one per cycle while m_ready is high; a report
// holds the back end until all of its events (up to 12) are out. Reports are taken every cycle while
// the job queue (QUEUE_DEPTH jobs) has room; reports that change no key use no slot.
// Reset (aresetn low, synchronous) clears previous keys, the queue and the output valid.
`default_nettype none
module hid_keyboard_report_to_key_events #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire hkr_pkg::report_t     s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output hkr_pkg::key_event_t       m_data
);

    logic          q_full, q_push, q_pop, q_head_valid;
    hkr_pkg::job_t q_push_job, q_head_job;

    hkr_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_job   (q_push_job)
    );

    hkr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (q_push_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_job   (q_head_job)
    );

    hkr_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head_job   (q_head_job),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
`default_nettype wire

@@ design/hkr_checker.sv @@
// Port-level checks for the key event decoder, bound to the top level.
// Depends on hkr_pkg and hid_keyboard_report_to_key_events.
`default_nettype none
module hkr_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire hkr_pkg::report_t    s_data,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire hkr_pkg::key_event_t m_data
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output word changed while stalled");

    // reset empties the output register
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // an ASCII event never carries code zero
    a_ascii_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.is_special |-> m_data.event_code != 8'd0)
        else $error("ASCII event with zero code");

    // events of one report share its modifier flags
    a_same_mods: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last_event |=>
            !m_valid ||
            (m_data.ctrl_held == $past(m_data.ctrl_held) &&
             m_data.shift_held == $past(m_data.shift_held) &&
             m_data.alt_held == $past(m_data.alt_held) &&
             m_data.altgr_held == $past(m_data.altgr_held)))
        else $error("modifier flags changed within a report");

endmodule

bind hid_keyboard_report_to_key_events hkr_checker u_hkr_checker (.*);
`default_nettype wire
